// ===== hw/rtl/iltab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iltab_pkg: shared types and constants for the integer list table engine
// Request and response transaction layouts, action and status codes.
// ----------------------------------------------------------------------------
package iltab_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        ACT_APPEND      = 3'd0,
        ACT_APPEND_UNIQ = 3'd1,
        ACT_SEARCH      = 3'd2,
        ACT_BSEARCH     = 3'd3,
        ACT_REMOVE      = 3'd4,
        ACT_CLEAR       = 3'd5,
        ACT_SORT_ASC    = 3'd6,
        ACT_SORT_DESC   = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_RESERVED  = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
        logic [7:0]         position;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] found_index;
        logic [8:0] entry_count;
    } rsp_t;

endpackage

// ===== hw/rtl/iltab_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iltab_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module iltab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hw/rtl/integer_list_table_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_list_table_engine_top: list store with search, remove and sort
// Sequencer over one single-port RAM and one shared 32-bit comparator.
// ----------------------------------------------------------------------------
// Usage:
//   req (req_valid / req_stall) carries one request transaction: action,
//   value, position. rsp (rsp_valid / rsp_stall) returns one transaction per
//   request: status, found_index, entry_count.
//   The block takes one request at a time; req_stall is high from accept
//   until the response has been taken.
//   All requests go through the one RAM port (one access per cycle); with
//   N entries held, the work per request is:
//     append, clear, reserved value: answered directly, with no walk
//     append_unique, search: linear walk over up to N entries
//     binary search: halves the range on each probe
//     remove: shifts the entries above position down one place
//     sort (insertion): each entry compared back against those before it
//   Reset empties the store (count to zero); RAM contents are left as they
//   are and never read above the count. A stalled response holds.
// ----------------------------------------------------------------------------
module integer_list_table_engine_top
    import iltab_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  iltab_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output iltab_pkg::rsp_t  rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = AW + 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_LREAD = 10'b0000000100,
        S_LCMP  = 10'b0000001000,
        S_BREAD = 10'b0000010000,
        S_BCMP  = 10'b0000100000,
        S_RREAD = 10'b0001000000,
        S_RWR   = 10'b0010000000,
        S_SORT  = 10'b0100000000,
        S_RESP  = 10'b1000000000
    } state_t;

    typedef enum logic [4:0] {
        P_KEYRD  = 5'b00001,
        P_KEYGET = 5'b00010,
        P_PRVRD  = 5'b00100,
        P_PRVCMP = 5'b01000,
        P_PLACE  = 5'b10000
    } sphase_t;

    state_t             state_reg, state_next;
    sphase_t            ph_reg, ph_next;
    req_t               cur_reg, cur_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [IW:0]        i_reg, i_next;      // signed-safe walk index (extra bit)
    logic [IW:0]        j_reg, j_next;
    logic signed [IW:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [31:0] key_reg, key_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rv_reg, rv_next;

    logic               we;
    logic [AW-1:0]      addr;
    logic [31:0]        wdata, rdata;
    logic signed [IW:0] mid;

    // Shared comparator: RAM word against the working key
    logic cmp_eq, cmp_lt, cmp_gt;
    logic signed [31:0] rd_s;
    assign rd_s   = rdata;
    assign cmp_eq = (rd_s == key_reg);
    assign cmp_lt = (rd_s < key_reg);
    assign cmp_gt = (rd_s > key_reg);

    assign mid = (lo_reg + hi_reg) >>> 1;

    iltab_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign req_stall = (state_reg != S_IDLE) || (rv_reg && rsp_stall);
    assign rsp_valid = rv_reg;
    assign rsp       = rsp_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        key_next   = key_reg;
        rsp_next   = rsp_reg;
        rv_next    = rv_reg;
        we         = 1'b0;
        addr       = i_reg[AW-1:0];
        wdata      = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (rv_reg && !rsp_stall)
                begin
                    rv_next = 1'b0;
                end
                if (req_valid && !(rv_reg && rsp_stall))
                begin
                    cur_next   = req;
                    key_next   = req.value;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                rsp_next.status      = ST_OK;
                rsp_next.found_index = '0;
                i_next     = '0;
                state_next = S_RESP;
                if (cur_reg.action <= ACT_BSEARCH && cur_reg.value == INT_MIN)
                begin
                    rsp_next.status = ST_RESERVED;
                end
                else
                begin
                    unique case (cur_reg.action)
                        ACT_APPEND:
                        begin
                            if (cnt_reg >= CW'(DEPTH))
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                we       = 1'b1;
                                addr     = cnt_reg[AW-1:0];
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        ACT_APPEND_UNIQ, ACT_SEARCH:
                        begin
                            state_next = S_LREAD;
                        end
                        ACT_BSEARCH:
                        begin
                            lo_next    = '0;
                            hi_next    = $signed({1'b0, IW'(cnt_reg)}) - (IW+1)'(1);
                            state_next = S_BREAD;
                        end
                        ACT_REMOVE:
                        begin
                            if ((IW+1)'(cur_reg.position) >= (IW+1)'(cnt_reg))
                            begin
                                rsp_next.status = ST_BAD_POS;
                            end
                            else
                            begin
                                i_next     = (IW+1)'(cur_reg.position);
                                state_next = S_RREAD;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                            i_next     = (IW+1)'(1);
                            ph_next    = P_KEYRD;
                            state_next = S_SORT;
                        end
                    endcase
                end
            end
            // Linear walk: read then compare
            S_LREAD:
            begin
                if (i_reg >= (IW+1)'(cnt_reg))
                begin
                    if (cur_reg.action == ACT_SEARCH)
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                    else if (cnt_reg >= CW'(DEPTH))
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        we       = 1'b1;
                        addr     = cnt_reg[AW-1:0];
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_LCMP;
                end
            end
            S_LCMP:
            begin
                if (cmp_eq)
                begin
                    if (cur_reg.action == ACT_SEARCH)
                    begin
                        rsp_next.found_index = i_reg[7:0];
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_LREAD;
                end
            end
            // Binary search: probe the midpoint
            S_BREAD:
            begin
                addr = mid[AW-1:0];
                if (lo_reg > hi_reg)
                begin
                    rsp_next.status = ST_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_BCMP;
                end
            end
            S_BCMP:
            begin
                state_next = S_BREAD;
                if (cmp_eq)
                begin
                    rsp_next.found_index = mid[7:0];
                    state_next           = S_RESP;
                end
                else if (cmp_lt)
                begin
                    lo_next = mid + (IW+1)'(1);
                end
                else
                begin
                    hi_next = mid - (IW+1)'(1);
                end
            end
            // Remove: shift entries down one place
            S_RREAD:
            begin
                if (i_reg + 1'b1 >= (IW+1)'(cnt_reg))
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    addr       = i_reg[AW-1:0] + 1'b1;
                    state_next = S_RWR;
                end
            end
            S_RWR:
            begin
                if (ph_reg == P_KEYRD)
                begin
                    addr    = i_reg[AW-1:0] + 1'b1;
                    ph_next = P_KEYGET;
                end
                else
                begin
                    we         = 1'b1;
                    wdata      = rdata;
                    ph_next    = P_KEYRD;
                    i_next     = i_reg + 1'b1;
                    state_next = S_RREAD;
                end
            end
            // Insertion sort
            S_SORT:
            begin
                unique case (ph_reg)
                    P_KEYRD:
                    begin
                        if (i_reg >= (IW+1)'(cnt_reg))
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            ph_next = P_KEYGET;
                        end
                    end
                    P_KEYGET:
                    begin
                        key_next = rdata;
                        j_next   = i_reg;
                        ph_next  = P_PRVRD;
                    end
                    P_PRVRD:
                    begin
                        if (j_reg == '0)
                        begin
                            ph_next = P_PLACE;
                        end
                        else
                        begin
                            addr    = j_reg[AW-1:0] - 1'b1;
                            ph_next = P_PRVCMP;
                        end
                    end
                    P_PRVCMP:
                    begin
                        addr = j_reg[AW-1:0] - 1'b1;
                        if ((cur_reg.action == ACT_SORT_DESC) ? cmp_lt : cmp_gt)
                        begin
                            we      = 1'b1;
                            addr    = j_reg[AW-1:0];
                            wdata   = rdata;
                            j_next  = j_reg - 1'b1;
                            ph_next = P_PRVRD;
                        end
                        else
                        begin
                            ph_next = P_PLACE;
                        end
                    end
                    default:
                    begin
                        we      = 1'b1;
                        addr    = j_reg[AW-1:0];
                        i_next  = i_reg + 1'b1;
                        ph_next = P_KEYRD;
                    end
                endcase
            end
            default:
            begin
                rsp_next.entry_count = 9'(cnt_reg);
                rv_next              = 1'b1;
                ph_next              = P_KEYRD;
                state_next           = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= P_KEYRD;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= rv_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

    // Count never exceeds the store size
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // No new request while a response is still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |-> req_stall || state_reg == S_IDLE)
        else $error("request taken over pending response");

    // A response follows from the response state only
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == S_RESP)
        else $error("response raised outside response state");

endmodule
